[design/elin_pkg.sv]
// ---------------------------------------------------------------------------
// elin_pkg: shared types and constants
// Register indexes, easing codes and parameter defaults for the eased
// linear interpolator.
// ---------------------------------------------------------------------------
`default_nettype none
package elin_pkg;

  localparam int TIME_BITS_DEF   = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int SINE_DEPTH_DEF  = 1024;

  // Fixed widths of the value channels and the configuration port
  localparam int VAL_BITS  = 32;
  localparam int CFG_BITS  = 32;
  localparam int IDX_BITS  = 3;
  localparam int MODE_BITS = 3;

  typedef enum logic [IDX_BITS-1:0] {
    REG_EASING_MODE = 3'd0,
    REG_START_A     = 3'd1,
    REG_END_A       = 3'd2,
    REG_START_B     = 3'd3,
    REG_END_B       = 3'd4
  } reg_idx_t;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_NONE   = 3'd0,
    MODE_LINEAR = 3'd1,
    MODE_SQUARE = 3'd2,
    MODE_SINE   = 3'd3,
    MODE_CUBE   = 3'd4
  } ease_mode_t;

  // Channel configuration seen by the interpolation stages
  typedef struct packed {
    logic signed [VAL_BITS-1:0] start_a;
    logic signed [VAL_BITS-1:0] end_a;
    logic signed [VAL_BITS-1:0] start_b;
    logic signed [VAL_BITS-1:0] end_b;
  } chan_cfg_t;

endpackage
`default_nettype wire

[design/elin_if.sv]
// ---------------------------------------------------------------------------
// elin_if: request and result channels
// Valid/ready channels carrying the particle time request and the result.
// ---------------------------------------------------------------------------
`default_nettype none
interface elin_in_if #(parameter int TIME_BITS = elin_pkg::TIME_BITS_DEF);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] elapsed_time;
  logic [TIME_BITS-1:0] life_span;
  modport source (output valid, elapsed_time, life_span, input ready);
  modport sink   (input valid, elapsed_time, life_span, output ready);
endinterface

interface elin_out_if #(parameter int FRAC_BITS = elin_pkg::FRAC_BITS_DEF);
  logic                                valid;
  logic                                ready;
  logic [FRAC_BITS:0]                  eased_factor;
  logic signed [elin_pkg::VAL_BITS-1:0] value_a;
  logic signed [elin_pkg::VAL_BITS-1:0] value_b;
  modport source (output valid, eased_factor, value_a, value_b, input ready);
  modport sink   (input valid, eased_factor, value_a, value_b, output ready);
endinterface
`default_nettype wire

[design/elin_div.sv]
// ---------------------------------------------------------------------------
// elin_div: progress divider
// Pipelined restoring division t = elapsed/life_span, one quotient bit per
// stage, saturated to one.
// ---------------------------------------------------------------------------
`default_nettype none
module elin_div #(
  parameter int TIME_BITS = elin_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS = elin_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [TIME_BITS-1:0] elapsed,
  input  wire logic [TIME_BITS-1:0] span,
  output logic                      out_valid,
  output logic [FRAC_BITS:0]        progress
);
  localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic                 v_r   [FRAC_BITS+1];
  logic                 sat_r [FRAC_BITS+1];
  logic [TIME_BITS-1:0] rem_r [FRAC_BITS+1];
  logic [TIME_BITS-1:0] div_r [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] q_r   [FRAC_BITS+1];

  // Capture stage: flag saturation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
    if (en) begin
      sat_r[0] <= (span == '0) || (elapsed >= span);
      rem_r[0] <= elapsed;
      div_r[0] <= span;
      q_r[0]   <= '0;
    end
  end

  // One restoring step per stage
  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
    logic [TIME_BITS:0] rem2;
    logic               ge;
    assign rem2 = {rem_r[k-1], 1'b0};
    assign ge   = rem2 >= {1'b0, div_r[k-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
      if (en) begin
        sat_r[k] <= sat_r[k-1];
        div_r[k] <= div_r[k-1];
        rem_r[k] <= ge ? TIME_BITS'(rem2 - {1'b0, div_r[k-1]}) : rem2[TIME_BITS-1:0];
        q_r[k]   <= {q_r[k-1][FRAC_BITS-2:0], ge};
      end
    end
  end

  assign out_valid = v_r[FRAC_BITS];
  assign progress  = sat_r[FRAC_BITS] ? ONE_Q : {1'b0, q_r[FRAC_BITS]};
endmodule
`default_nettype wire

[design/elin_ease.sv]
// ---------------------------------------------------------------------------
// elin_ease: easing curve
// Three stages: square and sine index, rounding with cube and sine read,
// curve select.
// ---------------------------------------------------------------------------
`default_nettype none
module elin_ease #(
  parameter int FRAC_BITS  = elin_pkg::FRAC_BITS_DEF,
  parameter int SINE_DEPTH = elin_pkg::SINE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic [elin_pkg::MODE_BITS-1:0] mode,
  input  wire logic                         in_valid,
  input  wire logic [FRAC_BITS:0]           progress,
  output logic                              out_valid,
  output logic [FRAC_BITS:0]                factor
);
  localparam int SB      = 28;
  localparam int PW2     = 2*FRAC_BITS + 2;
  localparam int IDX_W   = $clog2(SINE_DEPTH + 1);
  localparam int PWI     = FRAC_BITS + 2 + IDX_W;
  localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [PW2-1:0] HALF2 = PW2'(1) << (FRAC_BITS-1);
  localparam logic [PWI-1:0] HALFI = PWI'(1) << (FRAC_BITS-1);

  typedef logic [FRAC_BITS:0] rom_t [0:SINE_DEPTH];

  // Shift-and-subtract quotient for the table build
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      quo = quo << 1;
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Taylor series of sin(3.14*i/depth) in Q28, rounded to the fraction width
  function automatic logic [FRAC_BITS:0] sine_entry(input int unsigned i);
    logic [63:0]        x;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    x    = udiv64((64'(i) * 64'd314) << SB, 64'd100 * 64'(SINE_DEPTH));
    term = x;
    sum  = '0;
    for (int n = 1; n <= 25; n += 2) begin
      if (n[1]) sum = sum - $signed(term);
      else      sum = sum + $signed(term);
      term = (term * x) >> SB;
      term = udiv64(term, 64'(n + 1));
      term = (term * x) >> SB;
      term = udiv64(term, 64'(n + 2));
    end
    if (sum < 0) sum = '0;
    r = (64'(sum) + (64'd1 << (SB - 1 - FRAC_BITS))) >> (SB - FRAC_BITS);
    return (r > 64'(ONE_Q)) ? ONE_Q : r[FRAC_BITS:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t rom;
    for (int i = 0; i <= SINE_DEPTH; i++) rom[i] = sine_entry(i);
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic                 va_r, vb_r, vc_r;
  logic [FRAC_BITS:0]   ta_r, tb_r;
  logic [PW2-1:0]       sq_r;
  logic [IDX_W-1:0]     idx_r;
  logic [FRAC_BITS:0]   sqr_r;
  logic [PW2-1:0]       cube_r;
  logic [FRAC_BITS:0]   sine_r;
  logic [FRAC_BITS:0]   f_r;
  logic [PWI-1:0]       idx_prod;
  logic [PW2-1:0]       sq_rnd;
  logic [PW2-1:0]       cube_rnd;
  logic [FRAC_BITS:0]   sqr_nxt;
  logic [FRAC_BITS:0]   f_nxt;

  assign idx_prod = PWI'(progress) * PWI'(SINE_DEPTH) + HALFI;
  assign sq_rnd   = (sq_r + HALF2) >> FRAC_BITS;
  assign sqr_nxt  = sq_rnd[FRAC_BITS:0];
  assign cube_rnd = (cube_r + HALF2) >> FRAC_BITS;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  // Square product and sine index
  always_ff @(posedge clk) begin
    if (en) begin
      ta_r  <= progress;
      sq_r  <= PW2'(progress) * PW2'(progress);
      idx_r <= idx_prod[FRAC_BITS +: IDX_W];
    end
  end

  // Round square, form cube product, read sine table
  always_ff @(posedge clk) begin
    if (en) begin
      tb_r   <= ta_r;
      sqr_r  <= sqr_nxt;
      cube_r <= PW2'(sqr_nxt) * PW2'(ta_r);
      sine_r <= SINE_ROM[idx_r];
    end
  end

  // Select the curve
  always_comb begin
    case (mode)
      elin_pkg::MODE_LINEAR: f_nxt = tb_r;
      elin_pkg::MODE_SQUARE: f_nxt = sqr_r;
      elin_pkg::MODE_SINE:   f_nxt = sine_r;
      elin_pkg::MODE_CUBE:   f_nxt = cube_rnd[FRAC_BITS:0];
      default:               f_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) f_r <= f_nxt;
  end

  assign out_valid = vc_r;
  assign factor    = f_r;
endmodule
`default_nettype wire

[design/elin_lerp.sv]
// ---------------------------------------------------------------------------
// elin_lerp: channel interpolation
// start + round((end - start) * f) for channels a and b, three stages.
// ---------------------------------------------------------------------------
`default_nettype none
module elin_lerp #(
  parameter int FRAC_BITS = elin_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             en,
  input  wire elin_pkg::chan_cfg_t              chan,
  input  wire logic                             in_valid,
  input  wire logic [FRAC_BITS:0]               factor,
  output logic                                  out_valid,
  output logic [FRAC_BITS:0]                    out_factor,
  output logic signed [elin_pkg::VAL_BITS-1:0]  value_a,
  output logic signed [elin_pkg::VAL_BITS-1:0]  value_b
);
  localparam int VB = elin_pkg::VAL_BITS;
  localparam int DW = VB + 1;
  localparam int NW = DW + FRAC_BITS + 2;
  localparam logic signed [NW-1:0] HALF_N = NW'(1) << (FRAC_BITS-1);

  logic                  v1_r, v2_r, v3_r;
  logic [FRAC_BITS:0]    f1_r, f2_r, f3_r;
  logic signed [DW-1:0]  da_r, db_r;
  logic signed [VB-1:0]  sa1_r, sb1_r, sa2_r, sb2_r;
  logic signed [NW-1:0]  na_r, nb_r;
  logic signed [VB-1:0]  va_r, vb_r;
  logic signed [NW-1:0]  fs;
  logic signed [NW-1:0]  qa, qb;

  assign fs = $signed(NW'(f1_r));
  assign qa = na_r >>> FRAC_BITS;
  assign qb = nb_r >>> FRAC_BITS;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Differences, products, sums
  always_ff @(posedge clk) begin
    if (en) begin
      f1_r  <= factor;
      sa1_r <= chan.start_a;
      sb1_r <= chan.start_b;
      da_r  <= DW'(chan.end_a) - DW'(chan.start_a);
      db_r  <= DW'(chan.end_b) - DW'(chan.start_b);

      f2_r  <= f1_r;
      sa2_r <= sa1_r;
      sb2_r <= sb1_r;
      na_r  <= NW'(da_r) * fs + HALF_N;
      nb_r  <= NW'(db_r) * fs + HALF_N;

      f3_r  <= f2_r;
      va_r  <= sa2_r + qa[VB-1:0];
      vb_r  <= sb2_r + qb[VB-1:0];
    end
  end

  assign out_valid  = v3_r;
  assign out_factor = f3_r;
  assign value_a    = va_r;
  assign value_b    = vb_r;
endmodule
`default_nettype wire

[design/eased_linear_interpolator.sv]
// ---------------------------------------------------------------------------
// eased_linear_interpolator: particle progress, easing and interpolation
// Request channel in_req carries elapsed_time and life_span; result channel
// out_res carries eased_factor, value_a and value_b. The configuration port
// (cfg_we, cfg_index, cfg_data) writes easing_mode and the channel
// start/end values; write it only while no request is in flight.
// From request to result a request passes one capture stage and one divider
// stage per quotient bit, three easing stages, three interpolation stages and
// the output register. Throughput is one request per cycle, set by the fully
// pipelined divider, unless a receiver stall holds the pipeline.
// Reset empties the pipeline and the output register, sets easing_mode to
// linear and clears the channel values.
// When the receiver stalls, the result holds in the output register and the
// pipeline keeps accepting requests until its last stage fills; then
// in_req.ready drops until the result is taken.
// ---------------------------------------------------------------------------
`default_nettype none
module eased_linear_interpolator #(
  parameter int TIME_BITS        = elin_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS        = elin_pkg::FRAC_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = elin_pkg::SINE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  elin_in_if.sink                            in_req,
  elin_out_if.source                         out_res,
  input  wire logic                          cfg_we,
  input  wire logic [elin_pkg::IDX_BITS-1:0] cfg_index,
  input  wire logic [elin_pkg::CFG_BITS-1:0] cfg_data
);
  localparam int VB = elin_pkg::VAL_BITS;

  logic [elin_pkg::MODE_BITS-1:0] mode_r;
  elin_pkg::chan_cfg_t            chan_r;

  logic                 en;
  logic                 div_v, ease_v, lerp_v;
  logic [FRAC_BITS:0]   t, f, lerp_f;
  logic signed [VB-1:0] lerp_a, lerp_b;
  logic                 load;
  logic                 out_valid_r;
  logic [FRAC_BITS:0]   out_f_r;
  logic signed [VB-1:0] out_a_r, out_b_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= elin_pkg::MODE_LINEAR;
      chan_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        elin_pkg::REG_EASING_MODE: mode_r         <= cfg_data[elin_pkg::MODE_BITS-1:0];
        elin_pkg::REG_START_A:     chan_r.start_a <= cfg_data;
        elin_pkg::REG_END_A:       chan_r.end_a   <= cfg_data;
        elin_pkg::REG_START_B:     chan_r.start_b <= cfg_data;
        elin_pkg::REG_END_B:       chan_r.end_b   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the pipeline unless its last stage is full and cannot drain
  assign load         = out_res.ready || !out_valid_r;
  assign en           = load || !lerp_v;
  assign in_req.ready = en;

  elin_div #(.TIME_BITS(TIME_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_req.valid),
    .elapsed  (in_req.elapsed_time),
    .span     (in_req.life_span),
    .out_valid(div_v),
    .progress (t)
  );

  elin_ease #(.FRAC_BITS(FRAC_BITS), .SINE_DEPTH(SINE_TABLE_DEPTH)) u_ease (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .mode     (mode_r),
    .in_valid (div_v),
    .progress (t),
    .out_valid(ease_v),
    .factor   (f)
  );

  elin_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .chan      (chan_r),
    .in_valid  (ease_v),
    .factor    (f),
    .out_valid (lerp_v),
    .out_factor(lerp_f),
    .value_a   (lerp_a),
    .value_b   (lerp_b)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= lerp_v;
    end
    if (load) begin
      out_f_r <= lerp_f;
      out_a_r <= lerp_a;
      out_b_r <= lerp_b;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.eased_factor = out_f_r;
  assign out_res.value_a      = out_a_r;
  assign out_res.value_b      = out_b_r;
endmodule
`default_nettype wire

[design/elin_checker.sv]
// ---------------------------------------------------------------------------
// elin_checker: port-level checks
// Watches the top-level ports for reset, flow and range behavior.
// ---------------------------------------------------------------------------
`default_nettype none
module elin_checker #(
  parameter int FRAC_BITS = elin_pkg::FRAC_BITS_DEF
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [FRAC_BITS:0] eased_factor
);
  localparam logic [FRAC_BITS:0] ONE_Q = (FRAC_BITS+1)'(1) << FRAC_BITS;

  // Result held while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped under stall");

  // No result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Factor never exceeds one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> eased_factor <= ONE_Q)
    else $error("eased factor above one");

  // Requests flow whenever the output side can drain
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("request blocked with free output");
endmodule

bind eased_linear_interpolator elin_checker #(.FRAC_BITS(FRAC_BITS)) u_elin_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_req.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .eased_factor(out_res.eased_factor)
);
`default_nettype wire

[verif/tb_eased_linear_interpolator.sv]
// ---------------------------------------------------------------------------
// tb_eased_linear_interpolator: self-checking bench for the interpolator
// Drives particle time requests through the valid/ready channel under
// several idling phases and easing settings, predicts each result from
// the configured curve and channel values, and compares field by field.
// ---------------------------------------------------------------------------
module tb_eased_linear_interpolator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB       = elin_pkg::FRAC_BITS_DEF;
  localparam int DEPTH    = elin_pkg::SINE_DEPTH_DEF;
  localparam int LATENCY  = FB + 8;
  localparam longint ONE  = 64'd1 << FB;
  localparam longint HALF = 64'd1 << (FB - 1);
  localparam int N_RANDOM = 1200;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [FB:0]        factor;
    logic signed [31:0] val_a;
    logic signed [31:0] val_b;
  } interp_res_t;

  typedef struct {
    logic [31:0] elapsed;
    logic [31:0] span;
    logic        has_exp;
    logic [FB:0] exp_factor;
    logic signed [31:0] exp_a;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [elin_pkg::IDX_BITS-1:0] cfg_index;
  logic [elin_pkg::CFG_BITS-1:0] cfg_data;

  elin_in_if  in_ch();
  elin_out_if out_ch();

  eased_linear_interpolator dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_ch.sink), .out_res(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the registers
  logic [2:0]         ease_sel;
  logic signed [31:0] a_start, a_end, b_start, b_end;
  longint             sine_rom [0:DEPTH];

  interp_res_t pending_q[$];
  int     n_fail;
  longint cycles;
  int     send_idle_pct, recv_stall_pct;
  bit     hold_off;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Build the sine table by integer Taylor series in Q28
  function automatic longint sine_point(longint i);
    longint unsigned x, term;
    longint sum, r;
    x = ((i * 314) << 28) / (100 * DEPTH);
    term = x;
    sum = 0;
    for (int n = 1; n <= 25; n += 2) begin
      if (((n / 2) & 1) != 0) sum -= term;
      else sum += term;
      term = (term * x) >> 28;
      term = term / (n + 1);
      term = (term * x) >> 28;
      term = term / (n + 2);
    end
    if (sum < 0) sum = 0;
    r = (sum + (64'd1 << (27 - FB))) >>> (28 - FB);
    return (r > ONE) ? ONE : r;
  endfunction

  function automatic longint life_progress(logic [31:0] e, logic [31:0] s);
    longint unsigned rem, q;
    if (s == 0 || e >= s) return ONE;
    rem = e;
    q = 0;
    for (int i = 0; i < FB; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= s) begin
        rem -= s;
        q |= 1;
      end
    end
    return q;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b + HALF) >>> FB;
  endfunction

  function automatic logic [31:0] blend(logic signed [31:0] s0, logic signed [31:0] s1,
                                        longint f);
    longint d, n, q;
    d = longint'(s1) - longint'(s0);
    n = d * f + HALF;
    if (n >= 0) q = n >>> FB;
    else q = -((-n + ONE - 1) >>> FB);
    return 32'(longint'(s0) + q);
  endfunction

  function automatic interp_res_t interpolate(logic [31:0] e, logic [31:0] s);
    interp_res_t r;
    longint t, f;
    t = life_progress(e, s);
    case (ease_sel)
      elin_pkg::MODE_LINEAR: f = t;
      elin_pkg::MODE_SQUARE: f = qmul(t, t);
      elin_pkg::MODE_SINE:   f = sine_rom[(t * DEPTH + HALF) >>> FB];
      elin_pkg::MODE_CUBE:   f = qmul(qmul(t, t), t);
      default:               f = 0;
    endcase
    r.factor = f[FB:0];
    r.val_a = blend(a_start, a_end, f);
    r.val_b = blend(b_start, b_end, f);
    return r;
  endfunction

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    interp_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $error("result with no prediction waiting");
        n_fail++;
      end else begin
        want = pending_q.pop_front();
        if (out_ch.eased_factor !== want.factor) begin
          $error("eased_factor expected %0d actual %0d", want.factor, out_ch.eased_factor);
          n_fail++;
        end
        if (out_ch.value_a !== want.val_a) begin
          $error("value_a expected %0d actual %0d", want.val_a, out_ch.value_a);
          n_fail++;
        end
        if (out_ch.value_b !== want.val_b) begin
          $error("value_b expected %0d actual %0d", want.val_b, out_ch.value_b);
          n_fail++;
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(elin_pkg::reg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      elin_pkg::REG_EASING_MODE: ease_sel = data[2:0];
      elin_pkg::REG_START_A:     a_start = data;
      elin_pkg::REG_END_A:       a_end = data;
      elin_pkg::REG_START_B:     b_start = data;
      default:                   b_end = data;
    endcase
  endtask

  // Offer one request, hold it until taken; record prediction at acceptance
  task automatic send_request(logic [31:0] e, logic [31:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.elapsed_time <= e;
    in_ch.life_span <= s;
    do @(posedge clk); while (!in_ch.ready);
    pending_q.push_back(interpolate(e, s));
    @(negedge clk);
  endtask

  // Drop the request and wait for every expected result
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_time();
    case ($urandom_range(4))
      0: return $urandom();
      1: return $urandom_range(32'h0004_0000);
      2: return 32'hFFFF_FFFF - $urandom_range(255);
      default: return $urandom_range(32'h0100_0000);
    endcase
  endfunction

  task automatic random_config();
    write_reg(elin_pkg::REG_EASING_MODE, $urandom_range(7));
    write_reg(elin_pkg::REG_START_A, $urandom());
    write_reg(elin_pkg::REG_END_A, $urandom());
    write_reg(elin_pkg::REG_START_B,
              ($urandom_range(1)) ? $urandom() : $urandom_range(32'h00FF_FFFF));
    write_reg(elin_pkg::REG_END_B, $urandom());
  endtask

  stim_row_t directed [] = '{
    '{32'd0,          32'h0001_0000, 1'b1, 17'd0,     32'sd0},
    '{32'h0000_8000,  32'h0001_0000, 1'b1, 17'h08000, 32'sd0},
    '{32'd5,          32'd0,         1'b1, 17'h10000, 32'sd0},
    '{32'hFFFF_FFFF,  32'h0001_0000, 1'b1, 17'h10000, 32'sd0},
    '{32'h0001_0000,  32'h0001_0000, 1'b1, 17'h10000, 32'sd0},
    '{32'hFFFF_FFFE,  32'hFFFF_FFFF, 1'b0, 17'd0,     32'sd0},
    '{32'd1,          32'hFFFF_FFFF, 1'b0, 17'd0,     32'sd0},
    '{32'h5555_5555,  32'hAAAA_AAAA, 1'b0, 17'd0,     32'sd0},
    '{32'hAAAA_AAAA,  32'hFFFF_FFFF, 1'b0, 17'd0,     32'sd0},
    '{32'h0000_4000,  32'h0001_0000, 1'b0, 17'd0,     32'sd0}
  };

  initial begin
    logic [2:0] modes [5];
    int per_phase;
    modes = '{elin_pkg::MODE_NONE, elin_pkg::MODE_SQUARE, elin_pkg::MODE_SINE,
              elin_pkg::MODE_CUBE, 3'd7};
    for (int i = 0; i <= DEPTH; i++) sine_rom[i] = sine_point(i);
    n_fail = 0;
    cycles = 0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    ease_sel = elin_pkg::MODE_LINEAR;
    a_start = 0; a_end = 0; b_start = 0; b_end = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.elapsed_time = '0;
    in_ch.life_span = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows at reset values: linear, channels zero
    foreach (directed[k]) begin
      if (directed[k].has_exp) begin
        interp_res_t p;
        p = interpolate(directed[k].elapsed, directed[k].span);
        if (p.factor !== directed[k].exp_factor || p.val_a !== directed[k].exp_a) begin
          $error("table row %0d: factor expected %0d predicted %0d", k,
                 directed[k].exp_factor, p.factor);
          n_fail++;
        end
      end
      send_request(directed[k].elapsed, directed[k].span);
    end
    drain();

    // Extreme channel values in modes none, square, sine, cube and code 7
    write_reg(elin_pkg::REG_START_A, 32'h8000_0000);
    write_reg(elin_pkg::REG_END_A, 32'h7FFF_FFFF);
    write_reg(elin_pkg::REG_START_B, 32'h7FFF_FFFF);
    write_reg(elin_pkg::REG_END_B, 32'h8000_0000);
    foreach (modes[m]) begin
      write_reg(elin_pkg::REG_EASING_MODE, modes[m]);
      foreach (directed[k]) send_request(directed[k].elapsed, directed[k].span);
      drain();
    end

    // Random phases with differing idle mixes
    per_phase = N_RANDOM / 8;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      random_config();
      if (ph == 3) write_reg(elin_pkg::REG_EASING_MODE, elin_pkg::MODE_SINE);
      for (int k = 0; k < per_phase; k++) begin
        // Long receiver hold-off so the pipeline fills and backs up
        if (ph == 0 && k == 10) begin
          fork
            begin
              hold_off = 1'b1;
              repeat (3 * LATENCY) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
        end
        send_request(rand_time(), rand_time());
      end
      drain();
    end

    if (n_fail == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
